[rtl/min_max_priority_queue_defines.svh]
// Assertion macros used by the checker file of the priority queue.
`ifndef MIN_MAX_PRIORITY_QUEUE_DEFINES_SVH
`define MIN_MAX_PRIORITY_QUEUE_DEFINES_SVH

// Check that cons holds in the cycle after ante, outside reset.
`define MMPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("priority queue check failed");

// Check that cons holds in the cycle after ante, also across reset.
`define MMPQ_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("priority queue check failed");

`endif

[rtl/mmpq_pkg.sv]
// Types, constants and helpers of the min/max priority queue.
package mmpq_pkg;

  localparam int CAPACITY      = 64;
  localparam int DATA_WIDTH    = 32;
  localparam int COUNT_W       = $clog2(CAPACITY + 1);
  localparam int ENTRY_COUNT_W = 7;
  localparam int SORT_CNT_W    = $clog2(CAPACITY);
  localparam int ADDR_W        = 3;
  localparam int PDATA_W       = 32;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic REG_ORDER_MODE = 1'b0;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP,
    OP_SORT
  } op_t;

  typedef struct packed {
    logic                          cmd;
    logic signed [DATA_WIDTH-1:0]  value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  top_value;
    logic                          top_valid;
    logic [ENTRY_COUNT_W-1:0]      entry_count;
    logic [1:0]                    status;
  } rsp_t;

  typedef struct packed {
    op_t                           op;
    logic signed [DATA_WIDTH-1:0]  value;
    logic                          order;
    logic                          phase;
  } ctrl_t;

  // True if a ranks strictly ahead of b under the given order.
  function automatic logic beats(input logic signed [DATA_WIDTH-1:0] a,
                                 input logic signed [DATA_WIDTH-1:0] b,
                                 input logic order);
    return order ? (a < b) : (a > b);
  endfunction

endpackage

[rtl/mmpq_cell.sv]
// One slot of the sorted chain: insert, shift toward the head, or compare-swap.
module mmpq_cell (
  input  logic                                    clk,
  input  logic                                    rst,
  input  mmpq_pkg::ctrl_t                         ctrl,
  input  logic                                    pos_odd,
  input  logic signed [mmpq_pkg::DATA_WIDTH-1:0]  left_value,
  input  logic                                    left_valid,
  input  logic                                    left_keep,
  input  logic signed [mmpq_pkg::DATA_WIDTH-1:0]  right_value,
  input  logic                                    right_valid,
  output logic signed [mmpq_pkg::DATA_WIDTH-1:0]  value,
  output logic                                    valid,
  output logic                                    keep,
  output logic signed [mmpq_pkg::DATA_WIDTH-1:0]  value_next,
  output logic                                    valid_next
);

  logic is_left;

  assign keep    = valid && !mmpq_pkg::beats(ctrl.value, value, ctrl.order);
  assign is_left = (pos_odd == ctrl.phase);

  always_comb begin
    value_next = value;
    valid_next = valid;
    case (ctrl.op)
      mmpq_pkg::OP_PUSH: begin
        if (!keep) begin
          if (left_keep) begin
            value_next = ctrl.value;
            valid_next = 1'b1;
          end else begin
            value_next = left_value;
            valid_next = left_valid;
          end
        end
      end
      mmpq_pkg::OP_POP: begin
        value_next = right_value;
        valid_next = right_valid;
      end
      mmpq_pkg::OP_SORT: begin
        if (is_left) begin
          if (valid && right_valid && mmpq_pkg::beats(right_value, value, ctrl.order)) begin
            value_next = right_value;
          end
        end else begin
          if (valid && left_valid && mmpq_pkg::beats(value, left_value, ctrl.order)) begin
            value_next = left_value;
          end
        end
      end
      default: begin
        value_next = value;
        valid_next = valid;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

[rtl/mmpq_chain.sv]
// Row of cells kept sorted with the best entry in the head cell.
module mmpq_chain (
  input  logic                                    clk,
  input  logic                                    rst,
  input  mmpq_pkg::ctrl_t                         ctrl,
  output logic signed [mmpq_pkg::DATA_WIDTH-1:0]  head_value_next,
  output logic                                    head_valid_next
);

  logic signed [mmpq_pkg::DATA_WIDTH-1:0] cell_value      [mmpq_pkg::CAPACITY];
  logic                                   cell_valid      [mmpq_pkg::CAPACITY];
  logic                                   cell_keep       [mmpq_pkg::CAPACITY];
  logic signed [mmpq_pkg::DATA_WIDTH-1:0] cell_value_next [mmpq_pkg::CAPACITY];
  logic                                   cell_valid_next [mmpq_pkg::CAPACITY];

  for (genvar i = 0; i < mmpq_pkg::CAPACITY; i++) begin : g_cell
    logic signed [mmpq_pkg::DATA_WIDTH-1:0] l_value;
    logic                                   l_valid;
    logic                                   l_keep;
    logic signed [mmpq_pkg::DATA_WIDTH-1:0] r_value;
    logic                                   r_valid;

    if (i == 0) begin : g_head
      assign l_value = '0;
      assign l_valid = 1'b0;
      assign l_keep  = 1'b1;
    end else begin : g_inner_l
      assign l_value = cell_value[i-1];
      assign l_valid = cell_valid[i-1];
      assign l_keep  = cell_keep[i-1];
    end

    if (i == mmpq_pkg::CAPACITY - 1) begin : g_tail
      assign r_value = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner_r
      assign r_value = cell_value[i+1];
      assign r_valid = cell_valid[i+1];
    end

    mmpq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .pos_odd     (1'(i % 2)),
      .left_value  (l_value),
      .left_valid  (l_valid),
      .left_keep   (l_keep),
      .right_value (r_value),
      .right_valid (r_valid),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .keep        (cell_keep[i]),
      .value_next  (cell_value_next[i]),
      .valid_next  (cell_valid_next[i])
    );
  end

  assign head_value_next = cell_value_next[0];
  assign head_valid_next = cell_valid_next[0];

endmodule

[rtl/min_max_priority_queue.sv]
// Bounded min/max priority queue of signed values built on a sorted cell chain.
//
// Request channel (req_valid, req_stall, req): each beat pushes req.value
// (cmd push) or pops the best entry (cmd pop). Response channel (rsp_valid,
// rsp_stall, rsp): one beat per request with the best value left, whether
// any entry is held, the entry count and a status (done, push dropped on
// full, pop ignored on empty).
// A request is applied to every cell of the chain at once, so one request
// is taken per cycle while req_stall is low; its response is registered on acceptance and appears in the next cycle.
// The response sits in an output register; while it is stalled, req_stall
// rises and the chain holds.
// The APB register order_mode selects greatest-first (0) or least-first (1).
// A write to it starts a re-sort of the chain by odd-even compare-swap
// between neighbor cells, during which req_stall is high. Reads return the
// register value; pready is always high.
// Reset empties the queue, clears order_mode and drops any pending response.
module min_max_priority_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  mmpq_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output mmpq_pkg::rsp_t                  rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mmpq_pkg::ADDR_W-1:0]     paddr,
  input  logic [mmpq_pkg::PDATA_W-1:0]    pwdata,
  output logic [mmpq_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  typedef enum logic {
    S_IDLE,
    S_SORT
  } state_t;

  state_t                              state;
  logic                                order_mode;
  logic [mmpq_pkg::COUNT_W-1:0]        count;
  logic [mmpq_pkg::COUNT_W-1:0]        count_next;
  logic [mmpq_pkg::SORT_CNT_W-1:0]     sort_cnt;
  logic [1:0]                          status_next;
  logic                                accept;
  logic                                do_push;
  logic                                do_pop;
  logic                                cfg_write;
  logic                                full;
  logic                                empty;
  mmpq_pkg::ctrl_t                     ctrl;
  logic signed [mmpq_pkg::DATA_WIDTH-1:0] head_value_next;
  logic                                head_valid_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == mmpq_pkg::REG_ORDER_MODE);
  assign prdata    = (paddr[2] == mmpq_pkg::REG_ORDER_MODE) ?
                     mmpq_pkg::PDATA_W'(order_mode) : '0;

  assign req_stall = (state == S_SORT) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign full      = (count == mmpq_pkg::COUNT_W'(mmpq_pkg::CAPACITY));
  assign empty     = (count == '0);
  assign do_push   = accept && (req.cmd == mmpq_pkg::CMD_PUSH) && !full;
  assign do_pop    = accept && (req.cmd == mmpq_pkg::CMD_POP) && !empty;

  always_comb begin
    count_next  = count;
    status_next = mmpq_pkg::ST_DONE;
    if (req.cmd == mmpq_pkg::CMD_PUSH) begin
      if (full) begin
        status_next = mmpq_pkg::ST_FULL;
      end else begin
        count_next = count + 1'b1;
      end
    end else begin
      if (empty) begin
        status_next = mmpq_pkg::ST_EMPTY;
      end else begin
        count_next = count - 1'b1;
      end
    end
  end

  always_comb begin
    ctrl.value = req.value;
    ctrl.order = order_mode;
    ctrl.phase = sort_cnt[0];
    if (state == S_SORT) begin
      ctrl.op = mmpq_pkg::OP_SORT;
    end else if (do_push) begin
      ctrl.op = mmpq_pkg::OP_PUSH;
    end else if (do_pop) begin
      ctrl.op = mmpq_pkg::OP_POP;
    end else begin
      ctrl.op = mmpq_pkg::OP_HOLD;
    end
  end

  mmpq_chain u_chain (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .head_value_next (head_value_next),
    .head_valid_next (head_valid_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      order_mode <= 1'b0;
      count      <= '0;
      sort_cnt   <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_write) begin
            order_mode <= pwdata[0];
            sort_cnt   <= '0;
            state      <= S_SORT;
          end
        end
        S_SORT: begin
          if (cfg_write) begin
            order_mode <= pwdata[0];
            sort_cnt   <= '0;
          end else if (sort_cnt == mmpq_pkg::SORT_CNT_W'(mmpq_pkg::CAPACITY - 1)) begin
            state <= S_IDLE;
          end else begin
            sort_cnt <= sort_cnt + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
    if (accept) begin
      rsp.top_value   <= head_valid_next ? head_value_next : '0;
      rsp.top_valid   <= head_valid_next;
      rsp.entry_count <= mmpq_pkg::ENTRY_COUNT_W'(count_next);
      rsp.status      <= status_next;
    end
  end

endmodule

[rtl/mmpq_checker.sv]
// Port-level checks of the priority queue, bound to the top level.
`include "min_max_priority_queue_defines.svh"

module mmpq_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        req_valid,
  input logic                        req_stall,
  input mmpq_pkg::rsp_t              rsp,
  input logic                        rsp_valid,
  input logic                        rsp_stall,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [mmpq_pkg::ADDR_W-1:0] paddr
);

  logic req_beat;
  logic order_write;

  assign req_beat    = req_valid && !req_stall;
  assign order_write = psel && penable && pwrite && (paddr[2] == mmpq_pkg::REG_ORDER_MODE);

  `MMPQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `MMPQ_ASSERT_NEXT(a_req_to_rsp, clk, rst, req_beat, rsp_valid)
  `MMPQ_ASSERT_NEXT(a_resort_stalls, clk, rst, order_write, req_stall)
  `MMPQ_ASSERT_NEXT_ALWAYS(a_reset_clear, clk, rst, !rsp_valid && !req_stall)

endmodule

bind min_max_priority_queue mmpq_checker u_checker (.*);
